// ===== src/ordered_list_append_delete_assert.svh =====
// Assertion macros shared by the ordered list RTL.
`ifndef ORDERED_LIST_APPEND_DELETE_ASSERT_SVH
`define ORDERED_LIST_APPEND_DELETE_ASSERT_SVH

`ifndef SYNTHESIS

// A condition that holds at every clock edge outside reset.
`define OLAD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ordered list assertion failed");

// A consequence that holds in the same cycle as its cause.
`define OLAD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered list assertion failed");

// A consequence that holds in the cycle after its cause.
`define OLAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered list assertion failed");

`else

`define OLAD_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define OLAD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define OLAD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/olad_pkg.sv =====
// Package with the sizes, codes and types of the ordered list block.
package olad_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;
    localparam int OP_W  = 2;
    localparam int STS_W = 2;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd2;

    localparam logic [STS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL      = 2'd1;
    localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd2;

    typedef logic signed [VAL_W-1:0] t_val;

    typedef enum logic [1:0] {
        SEL_HOLD,
        SEL_NEXT,
        SEL_HEAD,
        SEL_IN
    } t_sel;

endpackage

// ===== src/olad_cell.sv =====
// One storage cell of the list chain: holds an entry, takes its neighbor, the head or new data.
module olad_cell (
    input  logic          i_clk,
    input  olad_pkg::t_sel i_sel,
    input  olad_pkg::t_val i_next,
    input  olad_pkg::t_val i_head,
    input  olad_pkg::t_val i_in,
    output olad_pkg::t_val o_value
);
    import olad_pkg::*;

    t_val r_value;
    t_val n_value;

    always_comb begin
        case (i_sel)
            SEL_HOLD: n_value = r_value;
            SEL_NEXT: n_value = i_next;
            SEL_HEAD: n_value = i_head;
            SEL_IN:   n_value = i_in;
            default:  n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== src/ordered_list_append_delete.sv =====
// Top level of the ordered list: control, cell chain and output register.
//
// The block keeps an ordered list of up to DEPTH signed 32-bit values in a row
// of cells, with the head in the first cell. The input stream carries the
// operation in s_axis_tuser and the value or key in s_axis_tdata. Append and
// delete give one status result; list gives one result per entry, the last
// one marked by m_axis_tlast, or a single empty result for an empty list.
// Each transfer is taken only while the controller is idle; one operation runs
// at a time. An append pushes its status result into the output register once
// that register is free. A delete rotates the entries one cell per cycle past
// the head compare, the match dropping out of the ring, and then pushes its
// status. A list emits one entry per cycle from the head of the rotating chain
// while the receiver accepts them, or its single empty result for an empty list.
// When the receiver stalls, the result waits in the output register, a list
// pauses its rotation with it, and no new transfer is taken until the running
// operation has pushed its final result into the output register.
// Synchronous reset empties the list and drops any pending result; the cell
// contents are left as they are and are never read before being written.
`include "ordered_list_append_delete_assert.svh"

module ordered_list_append_delete (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] item_value
    output logic [2:0]  m_axis_tuser,   // [1:0] status, [2] entry_valid
    output logic        m_axis_tlast
);
    import olad_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic             r_state;
    logic             n_state;
    logic [OP_W-1:0]  r_op;
    t_val             r_key;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_n;
    logic [CNT_W-1:0] r_step;
    logic [CNT_W-1:0] n_step;
    logic             r_found;
    logic             n_found;

    logic             r_ovalid;
    t_val             r_odata;
    logic [STS_W-1:0] r_ostatus;
    logic             r_oentry;
    logic             r_olast;

    t_val             w_val [DEPTH];
    t_sel             w_sel [DEPTH];
    t_val             w_head;
    logic [CNT_W-1:0] w_last_idx;
    logic             w_out_free;
    logic             w_hit;
    logic             w_load;
    logic             w_shift;
    logic             w_rot;
    logic             w_push;
    t_val             w_pdata;
    logic [STS_W-1:0] w_pstatus;
    logic             w_pentry;
    logic             w_plast;
    logic             w_accept;

    assign w_head     = w_val[0];
    assign w_last_idx = r_count - 1'b1;
    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_hit      = (w_head == r_key);
    assign w_accept   = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_step    = r_step;
        n_found   = r_found;
        w_load    = 1'b0;
        w_shift   = 1'b0;
        w_rot     = 1'b0;
        w_push    = 1'b0;
        w_pdata   = '0;
        w_pstatus = STS_OK;
        w_pentry  = 1'b0;
        w_plast   = 1'b1;
        if (r_state == S_RUN) begin
            case (r_op)
                OP_APPEND: begin
                    if (w_out_free) begin
                        w_push  = 1'b1;
                        n_state = S_IDLE;
                        if (r_count == CNT_W'(DEPTH)) begin
                            w_pstatus = STS_FULL;
                        end else begin
                            w_load  = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end
                end
                OP_DELETE: begin
                    if (r_step != r_n) begin
                        n_step = r_step + 1'b1;
                        if (!r_found && w_hit) begin
                            w_shift = 1'b1;
                            n_found = 1'b1;
                            n_count = r_count - 1'b1;
                        end else begin
                            w_rot = 1'b1;
                        end
                    end else if (w_out_free) begin
                        w_push    = 1'b1;
                        w_pstatus = r_found ? STS_OK : STS_NOT_FOUND;
                        n_state   = S_IDLE;
                    end
                end
                OP_LIST: begin
                    if (w_out_free) begin
                        w_push = 1'b1;
                        if (r_n == '0) begin
                            n_state = S_IDLE;
                        end else begin
                            w_pdata  = w_head;
                            w_pentry = 1'b1;
                            w_plast  = (r_step == r_n - 1'b1);
                            w_rot    = 1'b1;
                            n_step   = r_step + 1'b1;
                            if (w_plast) begin
                                n_state = S_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end else if (w_accept) begin
            if (s_axis_tuser inside {OP_APPEND, OP_DELETE, OP_LIST}) begin
                n_state = S_RUN;
            end
            n_step  = '0;
            n_found = 1'b0;
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam logic [CNT_W-1:0] LP_I = CNT_W'(i);
        t_val w_next;

        if (i == DEPTH - 1) begin : g_tail
            assign w_next = w_val[i];
        end else begin : g_mid
            assign w_next = w_val[i + 1];
        end

        always_comb begin
            w_sel[i] = SEL_HOLD;
            if (w_load && (LP_I == r_count)) begin
                w_sel[i] = SEL_IN;
            end else if (w_shift) begin
                w_sel[i] = SEL_NEXT;
            end else if (w_rot) begin
                if (LP_I < w_last_idx) begin
                    w_sel[i] = SEL_NEXT;
                end else if (LP_I == w_last_idx) begin
                    w_sel[i] = SEL_HEAD;
                end
            end
        end

        olad_cell u_cell (
            .i_clk   (i_clk),
            .i_sel   (w_sel[i]),
            .i_next  (w_next),
            .i_head  (w_head),
            .i_in    (r_key),
            .o_value (w_val[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_n      <= '0;
            r_step   <= '0;
            r_found  <= 1'b0;
            r_op     <= OP_APPEND;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
            r_found <= n_found;
            if (w_accept) begin
                r_op <= s_axis_tuser;
                r_n  <= r_count;
            end
            if (w_out_free) begin
                r_ovalid <= w_push;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= $signed(s_axis_tdata);
        end
        if (w_push) begin
            r_odata   <= w_pdata;
            r_ostatus <= w_pstatus;
            r_oentry  <= w_pentry;
            r_olast   <= w_plast;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = {r_oentry, r_ostatus};
    assign m_axis_tlast  = r_olast;

    `OLAD_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))
    `OLAD_ASSERT_IMPLY(a_step_bound, i_clk, i_rst_n, r_state == S_RUN, r_step <= r_n)
    `OLAD_ASSERT_IMPLY(a_entry_ok, i_clk, i_rst_n, r_ovalid && r_oentry, r_ostatus == STS_OK)
    `OLAD_ASSERT_NEXT(a_delete_one, i_clk, i_rst_n, r_state == S_RUN && r_op == OP_DELETE, r_count == $past(r_count) || r_count == CNT_W'($past(r_count) - 1'b1))

endmodule

// ===== test/ordered_list_append_delete_tb.sv =====
// Testbench for the ordered list block: directed and random list operations checked against a local model.
module ordered_list_append_delete_tb;
    import olad_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam t_val VAL_MIN = 32'sh8000_0000;
    localparam t_val VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        t_val             item_value;
        logic [STS_W-1:0] status;
        logic             entry_valid;
        logic             last;
    } t_list_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;   // [31:0] value
    logic [1:0]        s_axis_tuser = '0;   // [1:0] op
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;        // [31:0] item_value
    logic [2:0]        m_axis_tuser;        // [1:0] status, [2] entry_valid
    logic              m_axis_tlast;

    t_val              stored_vals[$];
    t_list_result      pending_results[$];
    int                err_count = 0;
    logic              quiet_mode = 1'b0;
    logic              rx_hold = 1'b0;

    ordered_list_append_delete dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= !rx_hold && (quiet_mode || $urandom_range(0, 99) >= 9);
    end

    function automatic t_list_result make_result(input t_val v, input logic [STS_W-1:0] st,
                                                 input logic valid, input logic last);
        t_list_result r;
        r.item_value = v;
        r.status = st;
        r.entry_valid = valid;
        r.last = last;
        return r;
    endfunction

    function automatic void model_list_op(input logic [OP_W-1:0] op, input t_val v);
        int pos;
        pos = -1;
        case (op)
            OP_APPEND: begin
                if (stored_vals.size() >= DEPTH) begin
                    pending_results.push_back(make_result('0, STS_FULL, 1'b0, 1'b1));
                end else begin
                    stored_vals.push_back(v);
                    pending_results.push_back(make_result('0, STS_OK, 1'b0, 1'b1));
                end
            end
            OP_DELETE: begin
                foreach (stored_vals[i]) begin
                    if (pos < 0 && stored_vals[i] == v) pos = i;
                end
                if (pos < 0) begin
                    pending_results.push_back(make_result('0, STS_NOT_FOUND, 1'b0, 1'b1));
                end else begin
                    stored_vals.delete(pos);
                    pending_results.push_back(make_result('0, STS_OK, 1'b0, 1'b1));
                end
            end
            OP_LIST: begin
                if (stored_vals.size() == 0) begin
                    pending_results.push_back(make_result('0, STS_OK, 1'b0, 1'b1));
                end else begin
                    foreach (stored_vals[i]) begin
                        pending_results.push_back(make_result(stored_vals[i], STS_OK, 1'b1,
                                                              i == stored_vals.size() - 1));
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = make_result(m_axis_tdata, m_axis_tuser[1:0], m_axis_tuser[2], m_axis_tlast);
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", m_axis_tdata, '0);
            end else begin
                want = pending_results.pop_front();
                if (got.item_value !== want.item_value)
                    report_mismatch("item_value", got.item_value, want.item_value);
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.entry_valid !== want.entry_valid)
                    report_mismatch("entry_valid", 32'(got.entry_valid),
                                    32'(want.entry_valid));
                if (got.last !== want.last)
                    report_mismatch("last", 32'(got.last), 32'(want.last));
            end
        end
    end

    task automatic send_op(input logic [OP_W-1:0] op, input t_val v);
        while (!quiet_mode && $urandom_range(0, 99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= v;
        s_axis_tuser <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        model_list_op(op, v);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_op(OP_LIST, $urandom);
        send_op(OP_DELETE, 32'sd7);
        send_op(OP_APPEND, VAL_MIN);
        send_op(OP_APPEND, VAL_MAX);
        send_op(OP_APPEND, '0);
        send_op(OP_APPEND, VAL_MAX);
        send_op(OP_APPEND, -32'sd1);
        send_op(OP_LIST, VAL_MIN);
        send_op(OP_DELETE, VAL_MAX);
        send_op(OP_DELETE, 32'sd5);
        send_op(OP_UNUSED, VAL_MAX);
        send_op(OP_LIST, -32'sd1);
        send_op(OP_DELETE, VAL_MIN);
        send_op(OP_DELETE, '0);
        send_op(OP_DELETE, -32'sd1);
        send_op(OP_DELETE, VAL_MAX);
        send_op(OP_LIST, '0);
        send_op(OP_DELETE, 32'sh5555_5555);
        send_op(OP_APPEND, 32'shaaaa_aaaa);
        send_op(OP_DELETE, 32'shaaaa_aaaa);
        send_op(OP_LIST, VAL_MAX);
        wait_drained();
    endtask

    task automatic test_full_list();
        while (stored_vals.size() < DEPTH) send_op(OP_APPEND, $urandom);
        send_op(OP_APPEND, $urandom);
        send_op(OP_APPEND, VAL_MAX);
        send_op(OP_LIST, $urandom);
        while (stored_vals.size() != 0)
            send_op(OP_DELETE, stored_vals[$urandom_range(0, stored_vals.size() - 1)]);
        send_op(OP_LIST, $urandom);
        wait_drained();
    endtask

    task automatic test_backpressure();
        fork
            begin
                rx_hold <= 1'b1;
                repeat (150) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        repeat (10) send_op(OP_APPEND, $urandom);
        send_op(OP_LIST, $urandom);
        send_op(OP_DELETE, $urandom);
        wait_drained();
    endtask

    task automatic random_mix(input int n_items, input int append_pct);
        int               done;
        int               pick;
        logic [OP_W-1:0]  op;
        t_val             v;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) op = OP_UNUSED;
            else if (pick < append_pct) op = OP_APPEND;
            else if (pick < 88) op = OP_DELETE;
            else op = OP_LIST;
            v = $urandom;
            if (op == OP_APPEND && $urandom_range(0, 1) == 1)
                v = $signed($urandom_range(0, 8)) - 32'sd4;
            if (op == OP_DELETE && stored_vals.size() != 0 && $urandom_range(0, 3) != 0)
                v = stored_vals[$urandom_range(0, stored_vals.size() - 1)];
            send_op(op, v);
            if (op != OP_UNUSED) done++;
        end
    endtask

    task automatic test_random();
        random_mix(40, 62);
        quiet_mode <= 1'b1;
        random_mix(30, 48);
        quiet_mode <= 1'b0;
        random_mix(40, 35);
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_list();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

endmodule
